### design/melody_tone_sequencer_unit_macros.svh
// Assertion macros shared by the melody tone sequencer RTL.
`ifndef MELODY_TONE_SEQUENCER_UNIT_MACROS_SVH
`define MELODY_TONE_SEQUENCER_UNIT_MACROS_SVH

// Property checked on every clock, off while reset is asserted.
`define MTSEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define MTSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mtseq_pkg.sv
// Types and constants for the melody tone sequencer.
`default_nettype none

package mtseq_pkg;

    localparam int NOTE_DEPTH_DEF = 256;

    // Opcodes of the input transaction
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_VOLUME_SHIFT = 2'd0;
    localparam logic [1:0] CFG_SONG_BASE    = 2'd1;
    localparam logic [1:0] CFG_SONG_LENGTH  = 2'd2;

    localparam logic [3:0] VOLUME_SHIFT_RST = 4'd2;
    localparam logic [7:0] DUTY_FULL        = 8'hFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  note_index;
        logic [7:0]  note_pitch_code;
        logic [15:0] note_ticks;
    } in_t;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic       playing;
        logic       song_done;
    } out_t;

    // One note memory entry
    typedef struct packed {
        logic [7:0]  pitch;
        logic [15:0] ticks;
    } note_t;

endpackage

`default_nettype wire

### design/melody_tone_sequencer_unit.sv
// Top level of the melody tone sequencer: tick-driven square-wave note player.
//
//  channel  | handshake          | payload                 | role
//  ---------+--------------------+-------------------------+-------------------------------
//  s_       | s_valid / s_ready  | s_data   (mtseq_pkg::in_t)  | tick, note write, start, stop
//  m_       | m_valid / m_ready  | m_data   (mtseq_pkg::out_t) | duty, playing, song done
//  cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_wdata    | volume shift, song base/length
//
//  - Each transaction is accepted into an input register and processed from there
//    into the result register; a new transaction every cycle while m_ does not stall.
//  - m_valid rises when the processed result is loaded into the result register.
//  - Both note reads (song base, next note) are registered every cycle from the
//    state that follows the current transaction, so a note load needs no wait.
//  - aresetn is synchronous, active low; it clears control and playback state.
//    The note memory is not cleared.
//  - A stalled m_ holds the result; s_ keeps accepting while the input register
//    can move on. NOTE_DEPTH must be a power of two.
`default_nettype none

`include "melody_tone_sequencer_unit_macros.svh"

module melody_tone_sequencer_unit #(
    parameter int NOTE_DEPTH = mtseq_pkg::NOTE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // input transactions
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire mtseq_pkg::in_t   s_data,
    // results
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mtseq_pkg::out_t       m_data,
    // configuration writes
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [8:0]       cfg_wdata
);

    localparam int AW    = $clog2(NOTE_DEPTH);
    localparam int SUM_W = (AW > 10) ? AW : 10;

    // configuration
    logic [3:0] volume_shift_reg;
    logic [7:0] song_base_reg;
    logic [8:0] song_length_reg;

    // input and result stages
    logic            item_valid_reg, item_valid_next;
    mtseq_pkg::in_t  item_reg;
    logic            out_valid_reg, out_valid_next;
    mtseq_pkg::out_t out_reg, out_next;

    // playback state
    logic [8:0]  note_offset_reg, note_offset_next;
    logic [9:0]  half_period_reg, half_period_next;
    logic [15:0] note_span_reg, note_span_next;
    logic [9:0]  half_count_reg, half_count_next;
    logic [15:0] span_count_reg, span_count_next;
    logic        level_high_reg, level_high_next;
    logic        active_reg, active_next;

    logic proceed;
    logic fire;
    logic done;
    logic [16:0] span_inc;
    logic [10:0] half_inc;

    // note memory ports
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    mtseq_pkg::note_t wr_note;
    logic [AW-1:0]    rd_base_addr;
    logic [AW-1:0]    rd_next_addr;
    mtseq_pkg::note_t rd_base_note;
    mtseq_pkg::note_t rd_next_note;
    logic [7:0]       base_now;

    assign proceed   = !out_valid_reg || m_ready;
    assign fire      = item_valid_reg && proceed;
    assign s_ready   = !item_valid_reg || proceed;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_shift_reg <= mtseq_pkg::VOLUME_SHIFT_RST;
            song_base_reg    <= '0;
            song_length_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                mtseq_pkg::CFG_VOLUME_SHIFT: volume_shift_reg <= cfg_wdata[3:0];
                mtseq_pkg::CFG_SONG_BASE:    song_base_reg    <= cfg_wdata[7:0];
                mtseq_pkg::CFG_SONG_LENGTH:  song_length_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- note memory ----------------
    // Base read follows a base write in the same cycle, so a start right after it is right.
    assign base_now = (cfg_valid && cfg_index == mtseq_pkg::CFG_SONG_BASE)
                      ? cfg_wdata[7:0] : song_base_reg;
    assign rd_base_addr = AW'(SUM_W'(base_now));
    // Next note relative to the offset the current transaction leaves behind.
    assign rd_next_addr = AW'(SUM_W'(base_now) + SUM_W'(note_offset_next) + SUM_W'(1));

    assign wr_en   = fire && item_reg.opcode == mtseq_pkg::OP_WRITE;
    assign wr_addr = AW'(SUM_W'(item_reg.note_index));
    assign wr_note = {item_reg.note_pitch_code, item_reg.note_ticks};

    mtseq_note_mem #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_note_mem (
        .aclk         (aclk),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_note      (wr_note),
        .rd_base_addr (rd_base_addr),
        .rd_next_addr (rd_next_addr),
        .rd_base_note (rd_base_note),
        .rd_next_note (rd_next_note)
    );

    // ---------------- transaction processing ----------------
    assign span_inc = {1'b0, span_count_reg} + 17'd1;
    assign half_inc = {1'b0, half_count_reg} + 11'd1;

    always_comb begin
        note_offset_next = note_offset_reg;
        half_period_next = half_period_reg;
        note_span_next   = note_span_reg;
        half_count_next  = half_count_reg;
        span_count_next  = span_count_reg;
        level_high_next  = level_high_reg;
        active_next      = active_reg;
        done             = 1'b0;

        if (fire) begin
            case (item_reg.opcode)
                mtseq_pkg::OP_START: begin
                    active_next      = 1'b0;
                    level_high_next  = 1'b0;
                    note_offset_next = '0;
                    if (song_length_reg != '0) begin
                        half_period_next = {rd_base_note.pitch, 2'b00};
                        note_span_next   = rd_base_note.ticks;
                        half_count_next  = '0;
                        span_count_next  = '0;
                        active_next      = 1'b1;
                    end
                end
                mtseq_pkg::OP_STOP: begin
                    active_next     = 1'b0;
                    level_high_next = 1'b0;
                end
                mtseq_pkg::OP_TICK: begin
                    if (active_reg) begin
                        if (span_inc < {1'b0, note_span_reg}) begin
                            span_count_next = span_inc[15:0];
                            if (half_period_reg != '0) begin
                                if (half_inc >= {1'b0, half_period_reg}) begin
                                    level_high_next = !level_high_reg;
                                    half_count_next = '0;
                                end else begin
                                    half_count_next = half_inc[9:0];
                                end
                            end
                        end else if ({1'b0, note_offset_reg} + 10'd1 < {1'b0, song_length_reg}) begin
                            // note over: next one was prefetched
                            note_offset_next = note_offset_reg + 9'd1;
                            half_period_next = {rd_next_note.pitch, 2'b00};
                            note_span_next   = rd_next_note.ticks;
                            half_count_next  = '0;
                            span_count_next  = '0;
                            level_high_next  = 1'b0;
                        end else begin
                            active_next     = 1'b0;
                            level_high_next = 1'b0;
                            done            = 1'b1;
                        end
                    end
                end
                default: ;  // note writes leave playback alone
            endcase
        end

        out_next.pwm_duty  = (active_next && level_high_next)
                             ? (mtseq_pkg::DUTY_FULL >> volume_shift_reg) : 8'd0;
        out_next.playing   = active_next;
        out_next.song_done = done;

        item_valid_next = s_ready ? s_valid : item_valid_reg;
        out_valid_next  = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            note_offset_reg <= '0;
            half_period_reg <= '0;
            note_span_reg   <= '0;
            half_count_reg  <= '0;
            span_count_reg  <= '0;
            level_high_reg  <= 1'b0;
            active_reg      <= 1'b0;
        end else begin
            item_valid_reg  <= item_valid_next;
            out_valid_reg   <= out_valid_next;
            note_offset_reg <= note_offset_next;
            half_period_reg <= half_period_next;
            note_span_reg   <= note_span_next;
            half_count_reg  <= half_count_next;
            span_count_reg  <= span_count_next;
            level_high_reg  <= level_high_next;
            active_reg      <= active_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    // ---------------- assertions ----------------
    `MTSEQ_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg, "processed transaction left no result")
    `MTSEQ_ASSERT(a_half_count_bound, !(active_reg && half_period_reg != '0) || half_count_reg < half_period_reg, "half-period counter overran")
    `MTSEQ_ASSERT(a_done_silent, !(out_valid_reg && out_reg.song_done) || (!out_reg.playing && out_reg.pwm_duty == 8'd0), "song done while still sounding")
    `MTSEQ_ASSERT(a_idle_silent, !(out_valid_reg && !out_reg.playing) || out_reg.pwm_duty == 8'd0, "duty nonzero while idle")

endmodule

`default_nettype wire

### design/mtseq_note_mem.sv
// Note memory: one write port, two registered read ports with write bypass.
`default_nettype none

module mtseq_note_mem #(
    parameter int NOTE_DEPTH = mtseq_pkg::NOTE_DEPTH_DEF,
    localparam int AW = $clog2(NOTE_DEPTH)
) (
    input  wire logic            aclk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire mtseq_pkg::note_t wr_note,
    input  wire logic [AW-1:0]   rd_base_addr,
    input  wire logic [AW-1:0]   rd_next_addr,
    output mtseq_pkg::note_t     rd_base_note,
    output mtseq_pkg::note_t     rd_next_note
);

    mtseq_pkg::note_t note_mem [NOTE_DEPTH];
    mtseq_pkg::note_t rd_base_reg;
    mtseq_pkg::note_t rd_next_reg;

    // A write in the same cycle is forwarded so a start right after a write sees it.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            note_mem[wr_addr] <= wr_note;
        end
        rd_base_reg <= (wr_en && wr_addr == rd_base_addr) ? wr_note : note_mem[rd_base_addr];
        rd_next_reg <= (wr_en && wr_addr == rd_next_addr) ? wr_note : note_mem[rd_next_addr];
    end

    assign rd_base_note = rd_base_reg;
    assign rd_next_note = rd_next_reg;

endmodule

`default_nettype wire
